/* hw/rtl/utf8sd_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; imported by every other file of the block.
package utf8sd_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CP_W    = 21;
   localparam int unsigned CNT_W   = 3;
   localparam int unsigned VALUE_W = 31;

   localparam logic [VALUE_W-1:0] MAX_SCALAR = 31'h0010_FFFF;
   localparam logic [VALUE_W-1:0] SURR_LO    = 31'h0000_D800;
   localparam logic [VALUE_W-1:0] SURR_HI    = 31'h0000_DFFF;

   localparam logic [BYTE_W-1:0] LEAD_OVERLONG_LO = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD_OVERLONG_HI = 8'hC1;
   localparam logic [BYTE_W-1:0] CONT_LO          = 8'h80;
   localparam logic [BYTE_W-1:0] LEAD_LO          = 8'hC0;
   localparam logic [BYTE_W-1:0] LEAD_SIX         = 8'hFC;
   localparam logic [BYTE_W-1:0] LEAD_FIVE        = 8'hF8;
   localparam logic [BYTE_W-1:0] LEAD_FOUR        = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD_THREE       = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD_INVALID     = 8'hFE;
   localparam logic [BYTE_W-1:0] CONT_MASK        = 8'h3F;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              end_mark;
   } req_type;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [CNT_W-1:0] byte_count;
   } rsp_type;

   // Handshake between the pipeline shell and the decode core
   typedef struct packed {
      logic    fire;
      req_type item;
   } step_type;

   typedef struct packed {
      logic    emit;
      rsp_type result;
   } emit_type;

endpackage

/* hw/rtl/utf8_stream_decoder.sv */
// Path: an accepted byte passes the input register, then the result register, to reach rsp_valid.
// Throughput: one byte per cycle; the input register and result register both advance
// whenever the result register is empty or its transfer completes.
// Reset (synchronous, active high) clears both valid bits and the pending sequence.
// Top level of the UTF-8 stream decoder; depends on utf8sd_pkg and utf8sd_core.
module utf8_stream_decoder (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  utf8sd_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output utf8sd_pkg::rsp_type rsp_data
);
   import utf8sd_pkg::*;

   logic     in_valid_ff, in_valid_in;
   req_type  in_data_ff;
   logic     out_valid_ff, out_valid_in;
   rsp_type  out_data_ff;
   logic     advance;
   step_type step;
   emit_type dec;

   assign advance     = !out_valid_ff || rsp_ready;
   assign req_ready   = !in_valid_ff || advance;
   assign in_valid_in = req_ready ? req_valid : in_valid_ff;
   assign step.fire   = in_valid_ff && advance;
   assign step.item   = in_data_ff;
   assign out_valid_in = advance ? (step.fire && dec.emit) : out_valid_ff;

   utf8sd_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .out   (dec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (step.fire && dec.emit) begin
         out_data_ff <= dec.result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

/* hw/rtl/utf8sd_core.sv */
// Decode core: sequence state registers and the per-byte decode step.
// Depends on utf8sd_pkg.
module utf8sd_core (
   input  logic                clock,
   input  logic                reset,
   input  utf8sd_pkg::step_type step,
   output utf8sd_pkg::emit_type out
);
   import utf8sd_pkg::*;

   logic [CNT_W-1:0]   exp_len_ff, exp_len_in;
   logic [CNT_W-1:0]   rx_cnt_ff, rx_cnt_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               overlong_ff, overlong_in;

   logic [BYTE_W-1:0]  b;
   logic               is_cont;
   logic [VALUE_W-1:0] shifted;
   logic [CNT_W-1:0]   cnt_next;
   logic               value_ok;
   logic [CNT_W-1:0]   lead_len;
   logic [VALUE_W-1:0] lead_bits;

   assign b        = step.item.data_byte;
   assign is_cont  = (b >= CONT_LO) && (b < LEAD_LO);
   assign shifted  = {value_ff[VALUE_W-7:0], b[5:0] & CONT_MASK[5:0]};
   assign cnt_next = rx_cnt_ff + 3'd1;
   assign value_ok = !overlong_ff && (shifted <= MAX_SCALAR) &&
                     !((shifted >= SURR_LO) && (shifted <= SURR_HI));

   always_comb begin
      priority if (b >= LEAD_SIX) begin
         lead_len  = 3'd6;
         lead_bits = {30'd0, b[0]};
      end else if (b >= LEAD_FIVE) begin
         lead_len  = 3'd5;
         lead_bits = {29'd0, b[1:0]};
      end else if (b >= LEAD_FOUR) begin
         lead_len  = 3'd4;
         lead_bits = {28'd0, b[2:0]};
      end else if (b >= LEAD_THREE) begin
         lead_len  = 3'd3;
         lead_bits = {27'd0, b[3:0]};
      end else begin
         lead_len  = 3'd2;
         lead_bits = {26'd0, b[4:0]};
      end
   end

   always_comb begin
      exp_len_in           = exp_len_ff;
      rx_cnt_in            = rx_cnt_ff;
      value_in             = value_ff;
      overlong_in          = overlong_ff;
      out.emit              = 1'b0;
      out.result.code_point = shifted[CP_W-1:0];
      out.result.byte_count = exp_len_ff;
      if (step.fire) begin
         if ((exp_len_ff != '0) && is_cont) begin
            value_in  = shifted;
            rx_cnt_in = cnt_next;
            if (cnt_next >= exp_len_ff) begin
               // sequence complete: emit if legal, then start fresh
               out.emit    = value_ok;
               exp_len_in  = '0;
               rx_cnt_in   = '0;
               value_in    = '0;
               overlong_in = 1'b0;
            end else if (step.item.end_mark) begin
               exp_len_in  = '0;
               rx_cnt_in   = '0;
               value_in    = '0;
               overlong_in = 1'b0;
            end
         end else begin
            // drop anything pending, then treat the byte as a lead
            exp_len_in  = '0;
            rx_cnt_in   = '0;
            value_in    = '0;
            overlong_in = 1'b0;
            if ((b != '0) && (b < CONT_LO)) begin
               out.emit              = 1'b1;
               out.result.code_point = {13'd0, b};
               out.result.byte_count = 3'd1;
            end else if ((b >= LEAD_LO) && (b < LEAD_INVALID) && !step.item.end_mark) begin
               exp_len_in  = lead_len;
               rx_cnt_in   = 3'd1;
               value_in    = lead_bits;
               overlong_in = (b == LEAD_OVERLONG_LO) || (b == LEAD_OVERLONG_HI);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff  <= '0;
         rx_cnt_ff   <= '0;
         value_ff    <= '0;
         overlong_ff <= 1'b0;
      end else begin
         exp_len_ff  <= exp_len_in;
         rx_cnt_ff   <= rx_cnt_in;
         value_ff    <= value_in;
         overlong_ff <= overlong_in;
      end
   end

endmodule

/* hw/rtl/utf8sd_checker.sv */
// Port-level checker for utf8_stream_decoder and its bind statement.
// Depends on utf8sd_pkg.
module utf8sd_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_ready,
   input utf8sd_pkg::req_type req_data,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input utf8sd_pkg::rsp_type rsp_data
);
   import utf8sd_pkg::*;

   // a stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_scalar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.byte_count >= 3'd1) && (rsp_data.byte_count <= 3'd6) &&
                    ({10'd0, rsp_data.code_point} <= MAX_SCALAR) &&
                    !(({10'd0, rsp_data.code_point} >= SURR_LO) &&
                      ({10'd0, rsp_data.code_point} <= SURR_HI)))
      else $error("illegal code point or byte count");

   a_ascii: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.byte_count == 3'd1) |->
         (rsp_data.code_point != '0) && (rsp_data.code_point < 21'h80))
      else $error("single byte result outside ASCII");

   // an ASCII byte with the output drained passes the input and result registers and appears at the output
   a_ascii_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_ready && (req_data.data_byte != '0) &&
      (req_data.data_byte < CONT_LO) ##1 rsp_ready |=>
         rsp_valid && (rsp_data.byte_count == 3'd1))
      else $error("ASCII byte not delivered");

endmodule

bind utf8_stream_decoder utf8sd_checker u_utf8sd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* sim/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for utf8_stream_decoder: feeds UTF-8 bytes, predicts code points.
// Depends on utf8sd_pkg and the decoder RTL; results are checked in order against a queue.
module testbench;
   import utf8sd_pkg::*;

   localparam int unsigned RANDOM_BYTES = 850;
   localparam int unsigned MAX_REPORTS  = 10;
   localparam int unsigned DRAIN_CYCLES = 16;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type pending_bytes[$];
   rsp_type expected_chars[$];
   int unsigned directed_count;
   int unsigned mismatch_count = 0;
   int send_gap   = 0;
   int send_calm  = 0;
   int recv_stall = 0;
   int recv_calm  = 0;

   // Predictor copy of the pending sequence
   logic [CNT_W-1:0]   seq_len;
   logic [CNT_W-1:0]   seq_seen;
   logic [VALUE_W-1:0] seq_value;
   logic               seq_overlong;

   utf8_stream_decoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial forever #2 clock = ~clock;

   function automatic void clear_sequence();
      seq_len      = '0;
      seq_seen     = '0;
      seq_value    = '0;
      seq_overlong = 1'b0;
   endfunction

   function automatic void decode_byte(input req_type item);
      logic [BYTE_W-1:0] b;
      rsp_type           ch;
      b = item.data_byte;
      if (seq_len != '0) begin
         if (b >= CONT_LO && b < LEAD_LO) begin
            seq_value = {seq_value[VALUE_W-7:0], b[5:0]};
            seq_seen  = seq_seen + 1'b1;
            if (seq_seen >= seq_len) begin
               if (!seq_overlong && seq_value <= MAX_SCALAR
                   && !(seq_value >= SURR_LO && seq_value <= SURR_HI)) begin
                  ch.code_point = seq_value[CP_W-1:0];
                  ch.byte_count = seq_len;
                  expected_chars.push_back(ch);
               end
               clear_sequence();
            end else if (item.end_mark) begin
               clear_sequence();
            end
            return;
         end
         // drop the broken sequence, then reparse this byte as a lead
         clear_sequence();
      end
      if (b == '0) return;
      if (b < CONT_LO) begin
         ch.code_point = CP_W'(b);
         ch.byte_count = CNT_W'(1);
         expected_chars.push_back(ch);
         return;
      end
      if (b < LEAD_LO || b >= LEAD_INVALID || item.end_mark) return;
      if (b >= LEAD_SIX) begin
         seq_len   = CNT_W'(6);
         seq_value = VALUE_W'(b & 8'h01);
      end else if (b >= LEAD_FIVE) begin
         seq_len   = CNT_W'(5);
         seq_value = VALUE_W'(b & 8'h03);
      end else if (b >= LEAD_FOUR) begin
         seq_len   = CNT_W'(4);
         seq_value = VALUE_W'(b & 8'h07);
      end else if (b >= LEAD_THREE) begin
         seq_len   = CNT_W'(3);
         seq_value = VALUE_W'(b & 8'h0F);
      end else begin
         seq_len   = CNT_W'(2);
         seq_value = VALUE_W'(b & 8'h1F);
      end
      seq_seen     = CNT_W'(1);
      seq_overlong = (b == LEAD_OVERLONG_LO || b == LEAD_OVERLONG_HI);
   endfunction

   // Mostly no idle, some short gaps, a few long ones, and runs of full rate
   function automatic int pick_idle(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   function automatic void queue_byte(input logic [BYTE_W-1:0] value, input logic last);
      req_type item;
      item.data_byte = value;
      item.end_mark  = last;
      pending_bytes.push_back(item);
   endfunction

   // Encode cp in n bytes, queue the first keep of them; last marks the final queued byte
   function automatic void queue_char(input int unsigned n, input int unsigned cp,
                                      input int unsigned keep, input logic last);
      int unsigned prefix;
      int unsigned value;
      prefix = (32'hFF << (8 - n)) & 32'hFF;
      for (int unsigned i = 0; i < keep; i++) begin
         if (n == 1)
            value = cp & 32'h7F;
         else if (i == 0)
            value = prefix | ((cp >> (6 * (n - 1))) & (32'hFF >> (n + 1)));
         else
            value = 32'h80 | ((cp >> (6 * (n - 1 - i))) & 32'h3F);
         queue_byte(value[BYTE_W-1:0], last && (i == keep - 1));
      end
   endfunction

   // Driver: present the next byte once the current one has transferred
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_sequence();
      end else begin
         if (req_valid && req_ready) decode_byte(req_data);
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_bytes.size() > 0) begin
               req_data  <= pending_bytes.pop_front();
               req_valid <= 1'b1;
               send_gap = pick_idle(send_calm);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transfer against the oldest prediction
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_chars.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("unexpected result: code_point %06h byte_count %0d",
                           rsp_data.code_point, rsp_data.byte_count);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_data.code_point !== want.code_point
                   || rsp_data.byte_count !== want.byte_count) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $display("result mismatch: expected %06h/%0d, got %06h/%0d",
                              want.code_point, want.byte_count,
                              rsp_data.code_point, rsp_data.byte_count);
               end
            end
            recv_stall = pick_idle(recv_calm);
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      int unsigned n;
      int unsigned cp;
      int unsigned roll;
      int unsigned len_roll;

      // ASCII extremes, zero byte inside a sequence, strays and invalid leads
      queue_byte(8'h01, 1'b0);
      queue_byte(8'h7F, 1'b0);
      queue_byte(8'hE2, 1'b0);
      queue_byte(8'h00, 1'b0);
      queue_byte(8'h80, 1'b0);
      queue_byte(8'hFE, 1'b0);
      queue_byte(8'hFF, 1'b0);
      // overlong C0 lead is consumed and dropped
      queue_char(2, 32'h0, 2, 1'b0);
      // surrogate, top scalar, just past the top, six-byte form
      queue_char(3, 32'hD800, 3, 1'b0);
      queue_char(4, 32'h10FFFF, 4, 1'b0);
      queue_char(4, 32'h110000, 4, 1'b0);
      queue_char(6, 32'h0, 6, 1'b0);
      // broken sequence: the ASCII byte is decoded as a new lead
      queue_byte(8'hE2, 1'b0);
      queue_byte(8'h41, 1'b0);
      // end mark on a lead, then a sequence that completes on the end mark
      queue_byte(8'hC2, 1'b1);
      queue_char(2, 32'hA9, 2, 1'b1);
      directed_count = pending_bytes.size();

      while (pending_bytes.size() < directed_count + RANDOM_BYTES) begin
         roll     = $urandom_range(0, 99);
         len_roll = $urandom_range(0, 99);
         if (len_roll < 25)      n = 1;
         else if (len_roll < 45) n = 2;
         else if (len_roll < 70) n = 3;
         else if (len_roll < 88) n = 4;
         else if (len_roll < 94) n = 5;
         else                    n = 6;
         cp = $urandom & ((32'd1 << ((n == 1) ? 7 : 5 * n + 1)) - 32'd1);
         if (n >= 4 && $urandom_range(0, 1) == 1) cp = $urandom_range(0, 32'h10FFFF);
         if (n == 3 && $urandom_range(0, 6) == 0) cp = $urandom_range(32'hD800, 32'hDFFF);
         if (roll < 72)
            queue_char(n, cp, n, $urandom_range(0, 9) == 0);
         else if (roll < 82 && n > 1)
            queue_char(n, cp, $urandom_range(1, n - 1), $urandom_range(0, 1) == 1);
         else if (roll < 88)
            queue_byte(8'h00, $urandom_range(0, 1) == 1);
         else if (roll < 96)
            queue_byte(BYTE_W'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
         else
            repeat ($urandom_range(1, 3))
               queue_byte(CONT_LO | BYTE_W'($urandom_range(0, 63)), 1'b0);
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_chars.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatch_count == 0 && expected_chars.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

/* files.f */
hw/rtl/utf8sd_pkg.sv
hw/rtl/utf8sd_core.sv
hw/rtl/utf8_stream_decoder.sv
hw/rtl/utf8sd_checker.sv
sim/testbench.sv
